@@ design/kowp_pkg.sv @@
// Package for the key object word parser.
// Holds phase, kind and error codes and the structs passed between modules; no dependencies.
package kowp_pkg;

	localparam int IV_BYTES_DEF  = 16;
	localparam int MAC_BYTES_DEF = 32;

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_HDR    = 6'b000010,
		PH_IV     = 6'b000100,
		PH_DMAGIC = 6'b001000,
		PH_DATA   = 6'b010000,
		PH_MAC    = 6'b100000
	} phase_t;

	localparam logic [2:0] KIND_HDR   = 3'd0;
	localparam logic [2:0] KIND_KEYID = 3'd1;
	localparam logic [2:0] KIND_ATTR  = 3'd2;
	localparam logic [2:0] KIND_USAGE = 3'd3;
	localparam logic [2:0] KIND_IV    = 3'd4;
	localparam logic [2:0] KIND_KEY   = 3'd5;
	localparam logic [2:0] KIND_PAD   = 3'd6;
	localparam logic [2:0] KIND_MAC   = 3'd7;

	localparam logic [2:0] ERR_OK       = 3'd0;
	localparam logic [2:0] ERR_MAGIC    = 3'd1;
	localparam logic [2:0] ERR_ALIGN    = 3'd2;
	localparam logic [2:0] ERR_KEYID    = 3'd3;
	localparam logic [2:0] ERR_USAGE    = 3'd4;
	localparam logic [2:0] ERR_DMAGIC   = 3'd5;
	localparam logic [2:0] ERR_MISMATCH = 3'd6;

	localparam logic REG_OBJECT_MAGIC = 1'b0;
	localparam logic REG_DATA_MAGIC   = 1'b1;

	typedef struct packed {
		logic [31:0] object_magic;
		logic [31:0] data_magic;
	} kowp_cfg_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  kind;
		logic [31:0] value;
		logic [14:0] key_size_bits;
		logic [2:0]  error;
		logic        last;
	} kowp_res_t;

endpackage

@@ design/kowp_cfg.sv @@
// APB register file for the key object word parser: object and data magic words.
// Depends on kowp_pkg.
module kowp_cfg
	import kowp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output kowp_cfg_t   cfg
);

	kowp_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_OBJECT_MAGIC: cfg_q.object_magic <= pwdata;
				REG_DATA_MAGIC:   cfg_q.data_magic   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_OBJECT_MAGIC: prdata = cfg_q.object_magic;
			REG_DATA_MAGIC:   prdata = cfg_q.data_magic;
			default:          prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign cfg    = cfg_q;

endmodule

@@ design/kowp_parse.sv @@
// Parse state and per-word decode of the key object word parser.
// Depends on kowp_pkg; fed by the input register of the top level.
module kowp_parse
	import kowp_pkg::*;
#(
	parameter int IV_BYTES  = IV_BYTES_DEF,
	parameter int MAC_BYTES = MAC_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [31:0] word,
	input  logic        first,
	input  kowp_cfg_t   cfg,
	output kowp_res_t   res
);

	localparam int IVW  = IV_BYTES / 4;
	localparam int MACW = MAC_BYTES / 4;
	localparam logic        HAS_IV   = (IVW > 0);
	localparam logic        HAS_MAC  = (MACW > 0);
	localparam logic [15:0] IV_END   = 16'(8 + IVW);
	localparam logic [15:0] DATA_BASE = 16'(9 + IVW);
	localparam logic [16:0] MAC_BASE = 17'(9 + IVW + MACW);

	phase_t      phase_q, phase_d;
	logic [15:0] position_q, position_d;
	logic [15:0] dsize_q, dsize_d;
	logic [10:0] dwords_q, dwords_d;
	logic [10:0] kwords_q, kwords_d;

	logic [15:0] pos_inc;
	logic [17:0] nbytes;
	logic        end_mac;
	logic        end_err;
	logic [15:0] idx;
	logic [7:0]  sz_byte;
	logic [8:0]  sz_inc;

	assign pos_inc = position_q + 16'd1;
	assign nbytes  = {pos_inc, 2'b00};
	assign end_mac = (nbytes < {2'b00, dsize_q}) && HAS_MAC;
	assign end_err = (nbytes != {2'b00, dsize_q});
	assign idx     = position_q - DATA_BASE;
	assign sz_byte = word[23:16];
	assign sz_inc  = {1'b0, sz_byte} + 9'd1;

	always_comb begin
		phase_d    = phase_q;
		position_d = position_q;
		dsize_d    = dsize_q;
		dwords_d   = dwords_q;
		kwords_d   = kwords_q;
		res        = '0;
		res.value  = word;
		if (first) begin
			phase_d    = PH_HDR;
			position_d = 16'd1;
			res.valid  = 1'b1;
			if (word != cfg.object_magic) begin
				res.error = ERR_MAGIC;
				res.last  = 1'b1;
			end
		end else begin
			case (phase_q)
				PH_HDR: begin
					position_d = pos_inc;
					res.valid  = 1'b1;
					if (position_q == 16'd1) begin
						dsize_d = word[15:0];
						if (word[1:0] != 2'b00) begin
							res.error = ERR_ALIGN;
							res.last  = 1'b1;
						end
					end else if (position_q == 16'd2) begin
						res.kind = KIND_KEYID;
						if (word == 32'd0) begin
							res.error = ERR_KEYID;
							res.last  = 1'b1;
						end
					end else if (position_q == 16'd5) begin
						res.kind          = KIND_ATTR;
						res.key_size_bits = {sz_byte, 7'd0};
						kwords_d          = {1'b0, sz_byte, 2'b00};
						dwords_d          = {sz_inc[8:1], 3'b000};
					end else if (position_q == 16'd6) begin
						res.kind = KIND_USAGE;
					end else if (position_q == 16'd7) begin
						if (word != 32'd0) begin
							res.error = ERR_USAGE;
							res.last  = 1'b1;
						end else begin
							phase_d = HAS_IV ? PH_IV : PH_DMAGIC;
						end
					end
				end
				PH_IV: begin
					position_d = pos_inc;
					res.valid  = 1'b1;
					res.kind   = KIND_IV;
					if (pos_inc >= IV_END) phase_d = PH_DMAGIC;
				end
				PH_DMAGIC: begin
					position_d = pos_inc;
					res.valid  = 1'b1;
					if (word != cfg.data_magic) begin
						res.error = ERR_DMAGIC;
						res.last  = 1'b1;
					end else if (dwords_q == 11'd0) begin
						if (end_mac) begin
							phase_d = PH_MAC;
						end else begin
							res.last  = 1'b1;
							res.error = end_err ? ERR_MISMATCH : ERR_OK;
						end
					end else begin
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					position_d = pos_inc;
					res.valid  = 1'b1;
					res.kind   = (idx < {5'd0, kwords_q}) ? KIND_KEY : KIND_PAD;
					if (({1'b0, idx} + 17'd1) >= {6'd0, dwords_q}) begin
						if (end_mac) begin
							phase_d = PH_MAC;
						end else begin
							res.last  = 1'b1;
							res.error = end_err ? ERR_MISMATCH : ERR_OK;
						end
					end
				end
				PH_MAC: begin
					position_d = pos_inc;
					res.valid  = 1'b1;
					res.kind   = KIND_MAC;
					if ({1'b0, pos_inc} >= (MAC_BASE + {6'd0, dwords_q})) begin
						res.last  = 1'b1;
						res.error = end_err ? ERR_MISMATCH : ERR_OK;
					end
				end
				default: ;
			endcase
		end
		if (res.valid && res.last) phase_d = PH_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			position_q <= '0;
			dsize_q    <= '0;
			dwords_q   <= '0;
			kwords_q   <= '0;
		end else if (take) begin
			phase_q    <= phase_d;
			position_q <= position_d;
			dsize_q    <= dsize_d;
			dwords_q   <= dwords_d;
			kwords_q   <= kwords_d;
		end
	end

endmodule

@@ design/key_object_word_parser.sv @@
// Key object word parser: one tagged result per word of a key object stream.
// No iteration: each beat passes the input and output registers to the master side.
// One word per cycle unless m_tready stalls; input register, decode, output register.
// Words with first low while no object is open are consumed without a result.
// Reset (arst_n, asynchronous): parser idle, counters zero, both magic registers zero.
// Depends on kowp_pkg, kowp_cfg and kowp_parse.
module key_object_word_parser
	import kowp_pkg::*;
#(
	parameter int IV_BYTES  = IV_BYTES_DEF,
	parameter int MAC_BYTES = MAC_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] word
	input  logic        s_tuser,   // [0] first
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [31:0] value, [46:32] key_size_bits, [49:47] error
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	kowp_cfg_t   cfg;
	kowp_res_t   res;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        first_s1;
	logic        valid_s2;
	kowp_res_t   res_s2;
	logic        adv;
	logic        take;

	assign adv      = !valid_s2 || m_tready;
	assign take     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	kowp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kowp_parse #(
		.IV_BYTES  (IV_BYTES),
		.MAC_BYTES (MAC_BYTES)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.word   (word_s1),
		.first  (first_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			word_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= take && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.error, res_s2.key_size_bits, res_s2.value};
	assign m_tuser  = res_s2.kind;
	assign m_tlast  = res_s2.last;

	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[49:47] != ERR_OK) |-> m_tlast)
		else $error("error result without last");

	a_ksb_attr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_ATTR) |-> (m_tdata[46:32] == 15'd0))
		else $error("key size on a non-attribute result");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

endmodule
